### hdl/upsd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// upsd_pkg - shared types and constants for the UPS patch stream decoder
// Field widths, result kinds, trailer layout, CRC-32 constants and a
// saturating address add.
// ============================================================================
package upsd_pkg;

    // Address / size arithmetic width (saturation point is 2^ADDR_BITS-1)
    localparam int ADDR_BITS = 32;
    localparam int FIELD_W   = 32;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int SHIFT_W   = 6;
    localparam int VLV_BITS  = 7;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [FIELD_W-1:0]   t_field;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [SHIFT_W-1:0]   t_shift;

    localparam t_addr  ADDR_MAX    = '1;
    localparam t_shift SHIFT_MAX   = '1;
    // shift limit compared against a one-bit-wider shift sum
    localparam logic [SHIFT_W:0] SHIFT_LIMIT = (SHIFT_W + 1)'(ADDR_BITS);
    localparam logic [SHIFT_W:0] SHIFT_STEP  = (SHIFT_W + 1)'(VLV_BITS);

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

    // Patch layout
    localparam t_field MIN_LENGTH    = 32'd16;
    localparam t_field TRAILER_BYTES = 32'd12;
    localparam t_field CRC_BYTES     = 32'd4;
    localparam t_field MAGIC_LAST    = 32'd3;
    localparam t_byte  END_BYTE      = 8'h00;

    // Trailer byte offsets that close a CRC word
    localparam logic [3:0] K_SRC_END = 4'd3;
    localparam logic [3:0] K_TGT_END = 4'd7;
    localparam logic [3:0] K_LAST    = 4'd11;

    // zlib CRC-32, reflected
    localparam t_field CRC_INIT = 32'hFFFF_FFFF;
    localparam t_field CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        t_addr  acc;
        t_shift shift;
        logic   last;
    } t_vlv;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        t_field            address;
        t_byte             xor_value;
        logic              beyond_source;
        t_field            source_size;
        t_field            target_size;
        t_field            source_crc;
        t_field            target_crc;
        logic              patch_crc_ok;
    } t_result;

    function automatic t_addr sat_add(input t_addr a, input t_addr b);
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[ADDR_BITS] ? ADDR_MAX : sum[ADDR_BITS-1:0];
    endfunction

endpackage

### hdl/upsd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// upsd_if - channel interfaces of the UPS patch stream decoder
// Patch byte input, configuration write and result output channels.
// ============================================================================
interface upsd_patch_if;
    logic                 valid;
    logic                 ready;
    upsd_pkg::t_byte      patch_byte;

    modport source (output valid, output patch_byte, input ready);
    modport sink   (input valid, input patch_byte, output ready);
endinterface

interface upsd_cfg_if;
    logic                 valid;
    logic                 ready;
    upsd_pkg::t_field     patch_length;

    modport source (output valid, output patch_length, input ready);
    modport sink   (input valid, input patch_length, output ready);
endinterface

interface upsd_result_if;
    logic                         valid;
    logic                         ready;
    logic [upsd_pkg::KIND_W-1:0]  kind;
    upsd_pkg::t_field             address;
    upsd_pkg::t_byte              xor_value;
    logic                         beyond_source;
    upsd_pkg::t_field             source_size;
    upsd_pkg::t_field             target_size;
    upsd_pkg::t_field             source_crc;
    upsd_pkg::t_field             target_crc;
    logic                         patch_crc_ok;

    modport source (
        output valid, output kind, output address, output xor_value,
        output beyond_source, output source_size, output target_size,
        output source_crc, output target_crc, output patch_crc_ok,
        input ready
    );
    modport sink (
        input valid, input kind, input address, input xor_value,
        input beyond_source, input source_size, input target_size,
        input source_crc, input target_crc, input patch_crc_ok,
        output ready
    );
endinterface

### hdl/ups_patch_stream_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// ups_patch_stream_decoder - streaming UPS patch decoder (top level)
// Input byte register, per-byte parse/CRC step, result register.
// ============================================================================
// Feed the patch one byte per request on i_patch after writing its total
// length (magic and 12-byte trailer included) on i_cfg; a length below 16
// is treated as 16. The block sustains one byte per clock unless a stalled
// result holds it: a byte is held in the input register, the parser and
// the CRC-32 byte update act on it, and any result lands in the output
// register, from which it is presented. Results: one header request with
// both sizes, one write request per nonzero XOR byte, and a final check
// request on the last byte. Bytes after the check are consumed silently
// until reset. Write lengths only while the block is idle.
// ============================================================================
module ups_patch_stream_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    upsd_cfg_if.sink      i_cfg,
    upsd_patch_if.sink    i_patch,
    upsd_result_if.source o_result
);

    // Configuration: patch length, always writable
    upsd_pkg::t_field  r_patch_length;

    // Input byte register
    logic              r_in_valid;
    upsd_pkg::t_byte   r_in_byte;

    // Result register
    logic              r_out_valid;
    upsd_pkg::t_result r_out;

    logic              w_step;
    logic              w_crc_en;
    upsd_pkg::t_field  w_crc;
    upsd_pkg::t_result w_result;

    // The held byte is processed when the result register has room
    // (empty, or being drained this cycle).
    assign w_step        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_patch.ready = !r_in_valid || w_step;
    assign i_cfg.ready   = 1'b1;

    upsd_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_crc_en),
        .i_byte  (r_in_byte),
        .o_crc   (w_crc)
    );

    upsd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_byte         (r_in_byte),
        .i_patch_length (r_patch_length),
        .i_crc          (w_crc),
        .o_crc_en       (w_crc_en),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_length <= upsd_pkg::MIN_LENGTH;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_patch_length <= i_cfg.patch_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_patch.valid && i_patch.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_patch.valid && i_patch.ready) begin
            r_in_byte <= i_patch.patch_byte;
        end
    end

    // Result register: bytes without a result just drain it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_result.valid;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_out.kind;
    assign o_result.address       = r_out.address;
    assign o_result.xor_value     = r_out.xor_value;
    assign o_result.beyond_source = r_out.beyond_source;
    assign o_result.source_size   = r_out.source_size;
    assign o_result.target_size   = r_out.target_size;
    assign o_result.source_crc    = r_out.source_crc;
    assign o_result.target_crc    = r_out.target_crc;
    assign o_result.patch_crc_ok  = r_out.patch_crc_ok;

    // A stalled result must never be overwritten by a new step.
    a_no_step_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !w_step)
        else $error("step taken while result stalled");

    // A held byte that is not processed stays held.
    a_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> r_in_valid)
        else $error("input byte lost");

    // Write requests always carry a nonzero XOR byte.
    a_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == upsd_pkg::KIND_WRITE) |-> (r_out.xor_value != '0))
        else $error("write request with zero xor value");

    // Nothing follows the final check request.
    a_check_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_result.ready && r_out.kind == upsd_pkg::KIND_CHECK)
        |=> !r_out_valid)
        else $error("result after final check");

endmodule

### hdl/upsd_vlv.sv
`timescale 1ns / 1ps
// ============================================================================
// upsd_vlv - UPS variable-length value byte step
// Adds one 7-bit group at the current shift, saturating at the address
// width; on a non-final byte adds the implicit 1 << (shift+7).
// ============================================================================
module upsd_vlv (
    input  upsd_pkg::t_addr  i_acc,
    input  upsd_pkg::t_shift i_shift,
    input  upsd_pkg::t_byte  i_byte,
    output upsd_pkg::t_vlv   o_next
);

    localparam int WIDE_W = upsd_pkg::ADDR_BITS + upsd_pkg::VLV_BITS;

    logic [WIDE_W-1:0]                w_term;
    logic                             w_sat;
    upsd_pkg::t_addr                  w_acc1;
    logic [upsd_pkg::SHIFT_W:0]       w_ns;

    always_comb begin
        w_term = {{upsd_pkg::ADDR_BITS{1'b0}}, i_byte[upsd_pkg::VLV_BITS-1:0]} << i_shift;
        w_sat  = (i_byte[upsd_pkg::VLV_BITS-1:0] != '0) &&
                 (({1'b0, i_shift} >= upsd_pkg::SHIFT_LIMIT) ||
                  (w_term[WIDE_W-1:upsd_pkg::ADDR_BITS] != '0));
        w_acc1 = w_sat ? upsd_pkg::ADDR_MAX
                       : upsd_pkg::sat_add(i_acc, w_term[upsd_pkg::ADDR_BITS-1:0]);
        w_ns   = {1'b0, i_shift} + upsd_pkg::SHIFT_STEP;

        o_next.last = i_byte[upsd_pkg::BYTE_W-1];
        if (i_byte[upsd_pkg::BYTE_W-1]) begin
            o_next.acc   = w_acc1;
            o_next.shift = i_shift;
        end else if (w_ns >= upsd_pkg::SHIFT_LIMIT) begin
            o_next.acc   = upsd_pkg::ADDR_MAX;
            o_next.shift = w_ns[upsd_pkg::SHIFT_W] ? upsd_pkg::SHIFT_MAX
                                                   : w_ns[upsd_pkg::SHIFT_W-1:0];
        end else begin
            o_next.acc   = upsd_pkg::sat_add(w_acc1,
                               upsd_pkg::t_addr'(1) << w_ns[upsd_pkg::SHIFT_W-1:0]);
            o_next.shift = w_ns[upsd_pkg::SHIFT_W-1:0];
        end
    end

endmodule

### hdl/upsd_crc.sv
`timescale 1ns / 1ps
// ============================================================================
// upsd_crc - running patch CRC-32
// zlib CRC-32 register, one byte folded in per enabled cycle.
// ============================================================================
module upsd_crc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  upsd_pkg::t_byte  i_byte,
    output upsd_pkg::t_field o_crc
);

    upsd_pkg::t_field r_crc;
    upsd_pkg::t_field n_crc;

    function automatic upsd_pkg::t_field crc_byte(input upsd_pkg::t_field c,
                                                  input upsd_pkg::t_byte b);
        upsd_pkg::t_field x;
        x = c ^ upsd_pkg::t_field'(b);
        for (int i = 0; i < upsd_pkg::BYTE_W; i++) begin
            x = x[0] ? ((x >> 1) ^ upsd_pkg::CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    always_comb begin
        n_crc = i_en ? crc_byte(r_crc, i_byte) : r_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= upsd_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

### hdl/upsd_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// upsd_parser - UPS patch field parser
// Tracks stream position and phase, decodes header sizes and records,
// collects the trailer and forms at most one result per byte.
// ============================================================================
module upsd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  upsd_pkg::t_byte   i_byte,
    input  upsd_pkg::t_field  i_patch_length,
    input  upsd_pkg::t_field  i_crc,
    output logic              o_crc_en,
    output upsd_pkg::t_result o_result
);

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_SRC     = 3'd1;
    localparam logic [2:0] PH_TGT     = 3'd2;
    localparam logic [2:0] PH_REL     = 3'd3;
    localparam logic [2:0] PH_XOR     = 3'd4;
    localparam logic [2:0] PH_TRAILER = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    logic [2:0]        r_phase,  n_phase;
    upsd_pkg::t_field  r_pos,    n_pos;
    upsd_pkg::t_addr   r_acc,    n_acc;
    upsd_pkg::t_shift  r_shift,  n_shift;
    upsd_pkg::t_addr   r_cursor, n_cursor;
    upsd_pkg::t_addr   r_src,    n_src;
    upsd_pkg::t_field  r_tw,     n_tw;
    upsd_pkg::t_field  r_scrc,   n_scrc;
    upsd_pkg::t_field  r_tcrc,   n_tcrc;

    upsd_pkg::t_vlv    w_vlv;
    upsd_pkg::t_field  w_len;
    upsd_pkg::t_field  w_tstart;
    upsd_pkg::t_field  w_koff;
    logic [3:0]        w_k;
    upsd_pkg::t_field  w_tw;

    upsd_vlv u_vlv (
        .i_acc   (r_acc),
        .i_shift (r_shift),
        .i_byte  (i_byte),
        .o_next  (w_vlv)
    );

    always_comb begin
        w_len    = (i_patch_length < upsd_pkg::MIN_LENGTH) ? upsd_pkg::MIN_LENGTH
                                                           : i_patch_length;
        w_tstart = w_len - upsd_pkg::TRAILER_BYTES;
        w_koff   = r_pos - w_tstart;
        w_k      = (w_koff > upsd_pkg::t_field'(upsd_pkg::K_LAST)) ? upsd_pkg::K_LAST
                                                                  : w_koff[3:0];
        w_tw     = r_tw | (upsd_pkg::t_field'(i_byte) << {w_k[1:0], 3'b000});

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_shift  = r_shift;
        n_cursor = r_cursor;
        n_src    = r_src;
        n_tw     = r_tw;
        n_scrc   = r_scrc;
        n_tcrc   = r_tcrc;
        o_crc_en = 1'b0;
        o_result = '0;

        if (i_step && r_phase != PH_DONE) begin
            n_pos    = r_pos + 32'd1;
            o_crc_en = r_pos < (w_len - upsd_pkg::CRC_BYTES);
            if (r_pos >= w_tstart) begin
                // trailer takes over from any phase
                n_phase = PH_TRAILER;
                n_tw    = w_tw;
                if (w_k == upsd_pkg::K_SRC_END) begin
                    n_scrc = w_tw;
                    n_tw   = '0;
                end else if (w_k == upsd_pkg::K_TGT_END) begin
                    n_tcrc = w_tw;
                    n_tw   = '0;
                end else if (w_k == upsd_pkg::K_LAST) begin
                    o_result.valid        = 1'b1;
                    o_result.kind         = upsd_pkg::KIND_CHECK;
                    o_result.source_crc   = r_scrc;
                    o_result.target_crc   = r_tcrc;
                    o_result.patch_crc_ok = (~i_crc == w_tw);
                    n_tw    = '0;
                    n_phase = PH_DONE;
                end
            end else begin
                unique case (r_phase)
                    PH_MAGIC: begin
                        if (r_pos >= upsd_pkg::MAGIC_LAST) begin
                            n_phase = PH_SRC;
                        end
                    end
                    PH_SRC: begin
                        n_acc   = w_vlv.acc;
                        n_shift = w_vlv.shift;
                        if (w_vlv.last) begin
                            n_src   = w_vlv.acc;
                            n_acc   = '0;
                            n_shift = '0;
                            n_phase = PH_TGT;
                        end
                    end
                    PH_TGT: begin
                        n_acc   = w_vlv.acc;
                        n_shift = w_vlv.shift;
                        if (w_vlv.last) begin
                            o_result.valid       = 1'b1;
                            o_result.kind        = upsd_pkg::KIND_HEADER;
                            o_result.source_size = upsd_pkg::FIELD_W'(r_src);
                            o_result.target_size = upsd_pkg::FIELD_W'(w_vlv.acc);
                            n_acc   = '0;
                            n_shift = '0;
                            n_phase = PH_REL;
                        end
                    end
                    PH_REL: begin
                        n_acc   = w_vlv.acc;
                        n_shift = w_vlv.shift;
                        if (w_vlv.last) begin
                            n_cursor = upsd_pkg::sat_add(r_cursor, w_vlv.acc);
                            n_acc    = '0;
                            n_shift  = '0;
                            n_phase  = PH_XOR;
                        end
                    end
                    PH_XOR: begin
                        if (i_byte == upsd_pkg::END_BYTE) begin
                            n_phase = PH_REL;
                        end else begin
                            o_result.valid         = 1'b1;
                            o_result.kind          = upsd_pkg::KIND_WRITE;
                            o_result.address       = upsd_pkg::FIELD_W'(r_cursor);
                            o_result.xor_value     = i_byte;
                            o_result.beyond_source = (r_cursor >= r_src);
                        end
                        n_cursor = upsd_pkg::sat_add(r_cursor, upsd_pkg::t_addr'(1));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_pos    <= '0;
            r_acc    <= '0;
            r_shift  <= '0;
            r_cursor <= '0;
            r_src    <= '0;
            r_tw     <= '0;
            r_scrc   <= '0;
            r_tcrc   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_shift  <= n_shift;
            r_cursor <= n_cursor;
            r_src    <= n_src;
            r_tw     <= n_tw;
            r_scrc   <= n_scrc;
            r_tcrc   <= n_tcrc;
        end
    end

endmodule

### sim/upsd_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// upsd_result_checker - result predictor and scoreboard for the UPS decoder
// Watches the length, patch byte and result channels, decodes each accepted
// byte itself and compares every accepted result with the oldest prediction.
// ============================================================================
module upsd_result_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    upsd_cfg_if     i_cfg,
    upsd_patch_if   i_patch,
    upsd_result_if  i_result,
    output int      o_fail_count,
    output int      o_pending
);

    localparam logic [63:0] SAT_LIMIT =
        (upsd_pkg::ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                    : ((64'd1 << upsd_pkg::ADDR_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PS_MAGIC,
        PS_SOURCE,
        PS_TARGET,
        PS_SKIP,
        PS_XOR,
        PS_TRAILER,
        PS_DONE
    } t_parse_step;

    typedef struct packed {
        logic [upsd_pkg::KIND_W-1:0] kind;
        upsd_pkg::t_field            address;
        upsd_pkg::t_byte             xor_value;
        logic                        beyond_source;
        upsd_pkg::t_field            source_size;
        upsd_pkg::t_field            target_size;
        upsd_pkg::t_field            source_crc;
        upsd_pkg::t_field            target_crc;
        logic                        patch_crc_ok;
    } t_decoded;

    t_decoded          awaited_results[$];

    upsd_pkg::t_field  length_reg;
    t_parse_step       parse_step;
    upsd_pkg::t_field  position;
    logic [63:0]       vlv_acc;
    int unsigned       vlv_shift;
    logic [63:0]       cursor;
    upsd_pkg::t_field  crc_run;
    logic [63:0]       src_size;
    upsd_pkg::t_field  trailer_acc;
    upsd_pkg::t_field  src_crc;
    upsd_pkg::t_field  tgt_crc;

    // saturating acc + (m << s)
    function automatic logic [63:0] scaled_sum(input logic [63:0] acc,
                                               input logic [63:0] m,
                                               input int unsigned s);
        logic [63:0] term;
        if (m == 0)
            return acc;
        if (s >= upsd_pkg::ADDR_BITS || s >= 64)
            return SAT_LIMIT;
        if (m > (SAT_LIMIT >> s))
            return SAT_LIMIT;
        term = m << s;
        if (acc > SAT_LIMIT || term > SAT_LIMIT - acc)
            return SAT_LIMIT;
        return acc + term;
    endfunction

    // one byte of a variable-length value; 1 when it ends the value
    function automatic bit take_vlv_byte(input upsd_pkg::t_byte b);
        int unsigned ns;
        vlv_acc = scaled_sum(vlv_acc, {57'd0, b[6:0]}, vlv_shift);
        if (b[7])
            return 1'b1;
        ns = vlv_shift + 7;
        if (ns >= upsd_pkg::ADDR_BITS || ns >= 64) begin
            vlv_acc   = SAT_LIMIT;
            vlv_shift = (ns > 63) ? 63 : ns;
        end else begin
            vlv_acc   = scaled_sum(vlv_acc, 64'd1, ns);
            vlv_shift = ns;
        end
        return 1'b0;
    endfunction

    function automatic upsd_pkg::t_field crc_byte(input upsd_pkg::t_field c,
                                                  input upsd_pkg::t_byte b);
        upsd_pkg::t_field r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ upsd_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic decode_patch_byte(input upsd_pkg::t_byte b);
        upsd_pkg::t_field eff_len;
        upsd_pkg::t_field tstart;
        upsd_pkg::t_field p;
        upsd_pkg::t_field k;
        t_decoded         r;
        if (parse_step == PS_DONE)
            return;
        eff_len  = (length_reg < upsd_pkg::MIN_LENGTH) ? upsd_pkg::MIN_LENGTH : length_reg;
        tstart   = eff_len - upsd_pkg::TRAILER_BYTES;
        p        = position;
        r        = '0;
        position = p + 32'd1;
        if (p < eff_len - upsd_pkg::CRC_BYTES)
            crc_run = crc_byte(crc_run, b);

        // trailer wins over whatever the parser was doing
        if (p >= tstart) begin
            k = p - tstart;
            if (k > upsd_pkg::K_LAST)
                k = upsd_pkg::t_field'(upsd_pkg::K_LAST);
            parse_step  = PS_TRAILER;
            trailer_acc = trailer_acc | ({24'd0, b} << (8 * k[1:0]));
            if (k == upsd_pkg::K_SRC_END) begin
                src_crc     = trailer_acc;
                trailer_acc = '0;
            end else if (k == upsd_pkg::K_TGT_END) begin
                tgt_crc     = trailer_acc;
                trailer_acc = '0;
            end else if (k == upsd_pkg::K_LAST) begin
                r.kind         = upsd_pkg::KIND_CHECK;
                r.source_crc   = src_crc;
                r.target_crc   = tgt_crc;
                r.patch_crc_ok = ((crc_run ^ upsd_pkg::CRC_INIT) == trailer_acc);
                trailer_acc    = '0;
                parse_step     = PS_DONE;
                awaited_results = {awaited_results, r};
            end
            return;
        end

        case (parse_step)
            PS_MAGIC: begin
                if (p >= upsd_pkg::MAGIC_LAST)
                    parse_step = PS_SOURCE;
            end
            PS_SOURCE: begin
                if (take_vlv_byte(b)) begin
                    src_size   = vlv_acc;
                    vlv_acc    = '0;
                    vlv_shift  = 0;
                    parse_step = PS_TARGET;
                end
            end
            PS_TARGET: begin
                if (take_vlv_byte(b)) begin
                    r.kind        = upsd_pkg::KIND_HEADER;
                    r.source_size = src_size[31:0];
                    r.target_size = vlv_acc[31:0];
                    vlv_acc       = '0;
                    vlv_shift     = 0;
                    parse_step    = PS_SKIP;
                    awaited_results = {awaited_results, r};
                end
            end
            PS_SKIP: begin
                if (take_vlv_byte(b)) begin
                    cursor     = scaled_sum(cursor, vlv_acc, 0);
                    vlv_acc    = '0;
                    vlv_shift  = 0;
                    parse_step = PS_XOR;
                end
            end
            PS_XOR: begin
                if (b == upsd_pkg::END_BYTE) begin
                    parse_step = PS_SKIP;
                end else begin
                    r.kind          = upsd_pkg::KIND_WRITE;
                    r.address       = cursor[31:0];
                    r.xor_value     = b;
                    r.beyond_source = (cursor >= src_size);
                    awaited_results = {awaited_results, r};
                end
                cursor = scaled_sum(cursor, 64'd1, 0);
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_result();
        t_decoded want;
        if (awaited_results.size() == 0) begin
            $error("result with nothing awaited: kind %0d", i_result.kind);
            o_fail_count++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(i_result.kind));
        compare_field("address", want.address, i_result.address);
        compare_field("xor_value", 32'(want.xor_value), 32'(i_result.xor_value));
        compare_field("beyond_source", 32'(want.beyond_source),
                      32'(i_result.beyond_source));
        compare_field("source_size", want.source_size, i_result.source_size);
        compare_field("target_size", want.target_size, i_result.target_size);
        compare_field("source_crc", want.source_crc, i_result.source_crc);
        compare_field("target_crc", want.target_crc, i_result.target_crc);
        compare_field("patch_crc_ok", 32'(want.patch_crc_ok), 32'(i_result.patch_crc_ok));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            length_reg   = upsd_pkg::MIN_LENGTH;
            parse_step   = PS_MAGIC;
            position     = '0;
            vlv_acc      = '0;
            vlv_shift    = 0;
            cursor       = '0;
            crc_run      = upsd_pkg::CRC_INIT;
            src_size     = '0;
            trailer_acc  = '0;
            src_crc      = '0;
            tgt_crc      = '0;
            o_fail_count = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1)
                length_reg = i_cfg.patch_length;
            if (i_patch.valid === 1'b1 && i_patch.ready === 1'b1)
                decode_patch_byte(i_patch.patch_byte);
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1)
                check_result();
        end
        o_pending = awaited_results.size();
    end

endmodule

### sim/tb_ups_patch_stream_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ups_patch_stream_decoder - testbench top for the UPS patch decoder
// Feeds one long patch: header and record corner cases first, then random
// records with some noise, a cursor overflow, an abandoned record and a
// trailer whose patch CRC is right or broken. Both sides idle at random.
// ============================================================================
module tb_ups_patch_stream_decoder;

    localparam int MAX_IDLE     = 13;   // longest gap / stall per request
    localparam int HOLD_CYCLES  = 80;   // long result hold-off, fills the block
    localparam int DRAIN_CYCLES = 8;    // pipeline is two deep, leave margin
    localparam int HOLD_AT      = 150;  // byte count where the hold-off starts
    localparam int PART_ONE_END = 320;
    localparam int PART_TWO_END = 600;

    logic   clk;
    logic   rst_n;
    int     fail_count;
    int     results_due;

    // stimulus state
    upsd_pkg::t_byte  rec_q[$];          // bytes of the record being built
    int unsigned      sent_count;        // bytes accepted so far
    upsd_pkg::t_field patch_crc;         // running CRC of the bytes sent
    bit               send_idle;         // sender gaps on or off for this stretch
    bit               hold_results;      // asks the receiver for one long hold-off
    bit               hold_done;
    int unsigned      results_seen;

    upsd_cfg_if    cfg_ch ();
    upsd_patch_if  patch_ch ();
    upsd_result_if result_ch ();

    ups_patch_stream_decoder u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_ch),
        .i_patch  (patch_ch),
        .o_result (result_ch)
    );

    upsd_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_patch      (patch_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_due)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // zlib CRC-32 of the stream, needed to build a trailer that matches
    function automatic upsd_pkg::t_field crc_next(input upsd_pkg::t_field c,
                                                  input upsd_pkg::t_byte b);
        upsd_pkg::t_field r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ upsd_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // append one byte to the record being built
    function automatic void add_byte(input upsd_pkg::t_byte b);
        rec_q = {rec_q, b};
    endfunction

    // UPS variable-length encoding: 7 bits per byte, top bit ends the value,
    // each continuation carries an implied +1
    function automatic void add_vlv(input longint unsigned v);
        longint unsigned rest;
        rest = v;
        forever begin
            if ((rest >> 7) == 0) begin
                add_byte(upsd_pkg::t_byte'({1'b1, rest[6:0]}));
                break;
            end
            add_byte(upsd_pkg::t_byte'({1'b0, rest[6:0]}));
            rest = (rest >> 7) - 1;
        end
    endfunction

    // One byte request. Inputs change on the falling edge; acceptance is
    // seen on the rising edge. valid stays high between back-to-back bytes.
    task automatic push_byte(input upsd_pkg::t_byte b);
        int gap;
        gap = send_idle ? $urandom_range(MAX_IDLE, 0) : 0;
        @(negedge clk);
        if (gap > 0) begin
            patch_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        patch_ch.valid      = 1'b1;
        patch_ch.patch_byte = b;
        do @(posedge clk); while (patch_ch.ready !== 1'b1);
        patch_crc = crc_next(patch_crc, b);
        sent_count++;
    endtask

    task automatic push_queue();
        foreach (rec_q[i])
            push_byte(rec_q[i]);
        rec_q.delete();
    endtask

    // well-formed record: skip value, 0..8 nonzero XOR bytes, end byte
    task automatic push_record();
        int unsigned     sel;
        int unsigned     count;
        longint unsigned skip;
        sel = $urandom_range(99, 0);
        if (sel < 80)
            skip = $urandom_range(40, 0);
        else if (sel < 98)
            skip = $urandom_range(400, 41);
        else
            skip = $urandom_range(20000, 401);
        add_vlv(skip);
        count = $urandom_range(8, 0);
        repeat (count) add_byte(upsd_pkg::t_byte'($urandom_range(255, 1)));
        add_byte(upsd_pkg::END_BYTE);
        push_queue();
    endtask

    // a few raw bytes that land wherever the parser happens to be
    task automatic push_noise();
        int unsigned count;
        count = $urandom_range(3, 1);
        repeat (count) push_byte(upsd_pkg::t_byte'($urandom_range(255, 0)));
    endtask

    task automatic push_random_until(input int unsigned stop_at);
        while (sent_count < stop_at) begin
            if (sent_count >= HOLD_AT && !hold_done) begin
                hold_results = 1'b1;
                hold_done    = 1'b1;
            end
            send_idle = ($urandom_range(3, 0) != 0);
            if ($urandom_range(11, 0) == 0)
                push_noise();
            else
                push_record();
        end
    endtask

    // stop offering bytes and let every awaited result come out
    task automatic settle();
        @(negedge clk);
        patch_ch.valid = 1'b0;
        wait (results_due == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // length writes only while the block is idle
    task automatic write_length(input upsd_pkg::t_field len);
        settle();
        cfg_ch.valid        = 1'b1;
        cfg_ch.patch_length = len;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Result side: a random stall before each result, in stretches with and
    // without stalls, plus the one long hold-off asked for by the sender.
    initial begin
        int  stall;
        bit  take_idle;
        result_ch.ready = 1'b0;
        results_seen    = 0;
        take_idle       = 1'b1;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_results) begin
                stall        = HOLD_CYCLES;
                hold_results = 1'b0;
            end else begin
                if (results_seen % 24 == 0)
                    take_idle = ($urandom_range(2, 0) != 0);
                stall = take_idle ? $urandom_range(MAX_IDLE, 0) : 0;
            end
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            results_seen++;
        end
    end

    initial begin
        upsd_pkg::t_field check_word;
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.patch_length = '0;
        patch_ch.valid      = 1'b0;
        patch_ch.patch_byte = '0;
        sent_count          = 0;
        patch_crc           = upsd_pkg::CRC_INIT;
        send_idle           = 1'b1;
        hold_results        = 1'b0;
        hold_done           = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Length extremes while idle: below the minimum, the minimum, and
        // the largest, which keeps the trailer out of reach for now.
        write_length(32'd0);
        write_length(upsd_pkg::MIN_LENGTH);
        write_length(32'hFFFF_FFFF);

        // magic, then source size 12000 (two-byte value)
        rec_q = '{8'h55, 8'h50, 8'h53, 8'h31};
        add_vlv(12000);
        // target size built from all-ones payloads, saturates the value
        add_byte(8'h7F);
        add_byte(8'h7F);
        add_byte(8'h7F);
        add_byte(8'h7F);
        add_byte(8'hFF);
        // skip 0, XOR bytes at both ends of the range and the top bit alone
        add_byte(8'h80);
        add_byte(8'hFF);
        add_byte(8'h01);
        add_byte(8'h80);
        add_byte(upsd_pkg::END_BYTE);
        // empty record: skip 0 and straight to the end byte
        add_byte(8'h80);
        add_byte(upsd_pkg::END_BYTE);
        // zero payload continuation: skip of 128
        add_byte(8'h00);
        add_byte(8'h80);
        add_byte(8'h7F);
        add_byte(upsd_pkg::END_BYTE);
        // largest one-byte skip
        add_byte(8'hFF);
        add_byte(8'h55);
        add_byte(upsd_pkg::END_BYTE);
        push_queue();

        // new length mid-stream; position carries on
        write_length(32'h8000_0000);
        push_random_until(PART_ONE_END);

        // full pause until every result is out, then another length
        write_length(upsd_pkg::t_field'($urandom_range(32'hFFFF_FFF0, 32'h0010_0000)));
        push_random_until(PART_TWO_END);

        // overflow the write cursor, then write at the ceiling
        send_idle = 1'b1;
        rec_q = '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'hFF};
        repeat (3) add_byte(upsd_pkg::t_byte'($urandom_range(255, 1)));
        add_byte(upsd_pkg::END_BYTE);
        add_byte(8'h80);
        add_byte(8'hFF);
        add_byte(upsd_pkg::END_BYTE);
        // record left open: the trailer cuts it off
        add_vlv($urandom_range(20, 0));
        repeat (2) add_byte(upsd_pkg::t_byte'($urandom_range(255, 1)));
        push_queue();

        // trailer starts at the very next byte
        write_length(sent_count + upsd_pkg::TRAILER_BYTES);
        repeat (8) push_byte(upsd_pkg::t_byte'($urandom_range(255, 0)));
        check_word = patch_crc ^ upsd_pkg::CRC_INIT;
        if ($urandom_range(1, 0) == 0)
            check_word = check_word ^ (32'd1 << $urandom_range(31, 0));
        for (int i = 0; i < 4; i++)
            push_byte(check_word[8*i +: 8]);

        // bytes after the check are swallowed without a result
        repeat (6) push_byte(upsd_pkg::t_byte'($urandom_range(255, 0)));

        settle();
        if (fail_count == 0 && results_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/upsd_pkg.sv
hdl/upsd_if.sv
hdl/upsd_vlv.sv
hdl/upsd_crc.sv
hdl/upsd_parser.sv
hdl/ups_patch_stream_decoder.sv
sim/upsd_result_checker.sv
sim/tb_ups_patch_stream_decoder.sv
